@@ hw/rtl/mksm_pkg.sv @@
// Shared types and constants for the multi-keyword stream matcher.
`timescale 1ns / 1ps

package mksm_pkg;

    localparam int KEY_REGS  = 4;    // lanes that have a keyword register
    localparam int KEY_W     = 64;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 4;
    localparam int POS_W     = 4;
    localparam int CNT_W     = 3;
    localparam int TICK_W    = 16;
    localparam int OP_W      = 2;
    localparam int LANE_ID_W = 3;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    localparam logic [CFG_IDX_W-1:0] REG_KEYWORD_A   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEYWORD_B   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEYWORD_C   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEYWORD_D   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTHS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 3'd6;

    typedef struct packed {
        logic active;   // lane in use with a nonzero length
        logic done;     // keyword completes on this byte
    } lane_stat_t;

endpackage

@@ hw/rtl/multi_keyword_stream_matcher_unit.sv @@
// Top level of the multi-keyword stream matcher.
`timescale 1ns / 1ps
//
// Watches a byte stream for up to four keywords of one to eight characters.
// Slave stream: s_tuser carries the request kind (start, byte, tick), s_tdata
// the received byte. Master stream: m_tdata carries the matched lane plus one
// (zero for none), m_tuser the timeout flag; a result leaves only when a
// search ends, by a keyword match or by the tick budget running out.
// Configuration: cfg_valid/cfg_ready with cfg_index selecting one of the
// keyword, length, count and timeout registers; write only while idle.
// Flow: a request is taken into an input register, and its result is
// loaded into the output register once that register can advance.
// Throughput is one request per cycle while the output is not stalled;
// every lane compares in parallel in the single stage between the two
// registers. A stalled receiver holds the output register; the input
// register then fills and s_tready drops until the result is taken.
// Reset clears all configuration registers, lane positions, the tick
// count and the searching flag; no result is pending after reset.
//
module multi_keyword_stream_matcher_unit
    import mksm_pkg::*;
#(
    parameter int LANES       = 4,
    parameter int MAX_KEY_LEN = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // slave stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,     // [7:0] rx_byte
    input  logic [OP_W-1:0]      s_tuser,     // [1:0] op
    // master stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,     // [2:0] match_lane, [7:3] zero
    output logic                 m_tuser,     // [0] timed_out
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KEY_W-1:0]     cfg_data
);

    localparam int LANE_CNT_W = 4;

    // configuration
    logic [KEY_W-1:0]  keyword_reg [KEY_REGS];
    logic [16-1:0]     key_lengths_reg;
    logic [CNT_W-1:0]  key_count_reg;
    logic [TICK_W-1:0] timeout_reg;

    // input register
    logic              in_valid_reg;
    logic [OP_W-1:0]   op_reg;
    logic [BYTE_W-1:0] byte_reg;

    // search state
    logic [POS_W-1:0]  pos_reg  [LANES];
    logic [POS_W-1:0]  pos_next [LANES];
    logic [TICK_W-1:0] elapsed_reg, elapsed_next;
    logic              searching_reg, searching_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [LANE_ID_W-1:0] match_lane_reg, match_lane_next;
    logic                 timed_out_reg, timed_out_next;

    logic                  advance;
    logic                  process;
    logic [LANE_CNT_W-1:0] used;
    logic [POS_W-1:0]      lane_pos [LANES];
    lane_stat_t            lane_stat [LANES];

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign process   = in_valid_reg && advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8-LANE_ID_W){1'b0}}, match_lane_reg};
    assign m_tuser  = timed_out_reg;

    assign used = (LANE_CNT_W'(key_count_reg) > LANE_CNT_W'(LANES)) ?
                  LANE_CNT_W'(LANES) : LANE_CNT_W'(key_count_reg);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < KEY_REGS; k++)
            begin
                keyword_reg[k] <= '0;
            end
            key_lengths_reg <= '0;
            key_count_reg   <= '0;
            timeout_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_KEYWORD_A:   keyword_reg[0]  <= cfg_data;
                REG_KEYWORD_B:   keyword_reg[1]  <= cfg_data;
                REG_KEYWORD_C:   keyword_reg[2]  <= cfg_data;
                REG_KEYWORD_D:   keyword_reg[3]  <= cfg_data;
                REG_KEY_LENGTHS: key_lengths_reg <= cfg_data[15:0];
                REG_KEY_COUNT:   key_count_reg   <= cfg_data[CNT_W-1:0];
                REG_TIMEOUT:     timeout_reg     <= cfg_data[TICK_W-1:0];
                default:         ;
            endcase
        end
    end

    // lanes
    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        if (i < KEY_REGS)
        begin : g_real
            mksm_lane #(
                .MAX_KEY_LEN (MAX_KEY_LEN)
            ) u_lane (
                .keyword  (keyword_reg[i]),
                .len_raw  (key_lengths_reg[LEN_W*i +: LEN_W]),
                .enable   (LANE_CNT_W'(i) < used),
                .pos      (pos_reg[i]),
                .rx_byte  (byte_reg),
                .pos_next (lane_pos[i]),
                .stat     (lane_stat[i])
            );
        end
        else
        begin : g_none
            // no keyword register: lane stays disabled
            assign lane_pos[i]         = pos_reg[i];
            assign lane_stat[i].active = 1'b0;
            assign lane_stat[i].done   = 1'b0;
        end
    end

    // next state and result
    always_comb
    begin
        logic blocked;
        logic [TICK_W-1:0] tick_inc;

        blocked  = 1'b0;
        tick_inc = (elapsed_reg == {TICK_W{1'b1}}) ? elapsed_reg : elapsed_reg + TICK_W'(1);

        for (int i = 0; i < LANES; i++)
        begin
            pos_next[i] = pos_reg[i];
        end
        elapsed_next    = elapsed_reg;
        searching_next  = searching_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        match_lane_next = match_lane_reg;
        timed_out_next  = timed_out_reg;

        if (process)
        begin
            case (op_reg)
                OP_START:
                begin
                    for (int i = 0; i < LANES; i++)
                    begin
                        pos_next[i] = '0;
                    end
                    elapsed_next   = '0;
                    searching_next = (timeout_reg != '0);
                    if (timeout_reg == '0)
                    begin
                        out_valid_next  = 1'b1;
                        match_lane_next = '0;
                        timed_out_next  = 1'b1;
                    end
                end
                OP_BYTE:
                begin
                    if (searching_reg)
                    begin
                        // lowest completing lane wins; lanes above it hold
                        for (int i = 0; i < LANES; i++)
                        begin
                            if (lane_stat[i].active && !blocked)
                            begin
                                pos_next[i] = lane_pos[i];
                                if (lane_stat[i].done)
                                begin
                                    blocked         = 1'b1;
                                    searching_next  = 1'b0;
                                    out_valid_next  = 1'b1;
                                    match_lane_next = LANE_ID_W'(i + 1);
                                    timed_out_next  = 1'b0;
                                end
                            end
                        end
                    end
                end
                OP_TICK:
                begin
                    if (searching_reg)
                    begin
                        elapsed_next = tick_inc;
                        if (tick_inc >= timeout_reg)
                        begin
                            searching_next  = 1'b0;
                            out_valid_next  = 1'b1;
                            match_lane_next = '0;
                            timed_out_next  = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            for (int i = 0; i < LANES; i++)
            begin
                pos_reg[i] <= '0;
            end
            elapsed_reg   <= '0;
            searching_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            for (int i = 0; i < LANES; i++)
            begin
                pos_reg[i] <= pos_next[i];
            end
            elapsed_reg   <= elapsed_next;
            searching_reg <= searching_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg   <= s_tuser;
            byte_reg <= s_tdata;
        end
        match_lane_reg <= match_lane_next;
        timed_out_reg  <= timed_out_next;
    end

endmodule

@@ hw/rtl/mksm_lane.sv @@
// One matcher lane: compares a byte against the keyword at the current position.
`timescale 1ns / 1ps

module mksm_lane
    import mksm_pkg::*;
#(
    parameter int MAX_KEY_LEN = 8
)
(
    input  logic [KEY_W-1:0]  keyword,
    input  logic [LEN_W-1:0]  len_raw,
    input  logic              enable,
    input  logic [POS_W-1:0]  pos,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic [POS_W-1:0]  pos_next,
    output lane_stat_t        stat
);

    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] cur_char;
    logic              hit;
    logic [POS_W-1:0]  pos_inc;

    // clamp long lengths
    assign len = (len_raw > LEN_W'(MAX_KEY_LEN)) ? LEN_W'(MAX_KEY_LEN) : len_raw;

    assign cur_char = keyword[pos[2:0]*BYTE_W +: BYTE_W];
    // a stale position at or past the length counts as a mismatch
    assign hit     = (pos < POS_W'(len)) && (rx_byte == cur_char);
    assign pos_inc = pos + POS_W'(1);

    always_comb
    begin
        if (hit)
        begin
            pos_next = pos_inc;
        end
        else
        begin
            pos_next = (rx_byte == keyword[BYTE_W-1:0]) ? POS_W'(1) : POS_W'(0);
        end
        stat.active = enable && (len != '0);
        stat.done   = stat.active && hit && (pos_inc == POS_W'(len));
    end

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the multi-keyword stream matcher.
`timescale 1ns / 1ps

module testbench;
    import mksm_pkg::*;

    localparam int LANES        = 4;
    localparam int MAX_KEY_LEN  = 8;
    localparam int RANDOM_ITEMS = 550;
    localparam int PHASE_ITEMS  = 40;
    localparam int MAX_GAP      = 17;
    localparam int SETTLE_CYC   = 4;

    localparam logic [OP_W-1:0]      OP_UNUSED    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    typedef struct packed {
        logic [LANE_ID_W-1:0] lane;
        logic                 timed_out;
    } search_end_t;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [KEY_W-1:0]     data;       // register value, or rx byte in [7:0]
        logic [OP_W-1:0]      op;
        logic                 typed;      // result given in the row
        logic [LANE_ID_W-1:0] lane;
        logic                 timed_out;
    } stim_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata   = '0;
    logic [OP_W-1:0]      s_tuser   = OP_START;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [KEY_W-1:0]     cfg_data  = '0;

    // shadow of the block's registers and search state
    logic [KEY_W-1:0]  key_reg [KEY_REGS];
    logic [15:0]       key_lens;
    logic [CNT_W-1:0]  key_count;
    logic [TICK_W-1:0] timeout_reg;
    logic [POS_W-1:0]  lane_pos [LANES];
    logic [TICK_W-1:0] elapsed;
    logic              search_on;

    search_end_t pending_ends [$];
    stim_row_t   directed_rows [$];
    logic [7:0]  burst_q [$];

    bit tx_idle_on;
    bit rx_idle_on;
    int errors;
    int live_items;
    int n_matches;
    int n_timeouts;
    int phases;

    multi_keyword_stream_matcher_unit #(
        .LANES       (LANES),
        .MAX_KEY_LEN (MAX_KEY_LEN)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        errors++;
        if (errors <= 100)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    function automatic int lane_len(input int lane);
        int len;
        len = int'(key_lens[4*lane +: 4]);
        return (len > MAX_KEY_LEN) ? MAX_KEY_LEN : len;
    endfunction

    // Advance the shadow search by one request; returns 1 when the search ends.
    function automatic logic matcher_step(input logic [OP_W-1:0] op, input logic [7:0] b,
                                          output search_end_t verdict);
        int         used;
        int         i;
        int         len;
        logic [3:0] p;
        logic       hit;
        verdict = '0;
        if (op == OP_START)
        begin
            for (i = 0; i < LANES; i++)
                lane_pos[i] = '0;
            elapsed   = '0;
            search_on = 1'b1;
            if (timeout_reg == '0)
            begin
                search_on         = 1'b0;
                verdict.timed_out = 1'b1;
                return 1'b1;
            end
            return 1'b0;
        end
        if (!search_on)
            return 1'b0;
        if (op == OP_BYTE)
        begin
            used = (int'(key_count) > LANES) ? LANES : int'(key_count);
            for (i = 0; i < used; i++)
            begin
                len = lane_len(i);
                if (len != 0)
                begin
                    p   = lane_pos[i];
                    hit = 1'b0;
                    if (p < len)
                        hit = (b == key_reg[i][8*p +: 8]);
                    if (hit)
                    begin
                        p           = p + 1'b1;
                        lane_pos[i] = p;
                        if (p == len)
                        begin
                            search_on    = 1'b0;
                            verdict.lane = LANE_ID_W'(i + 1);
                            return 1'b1;
                        end
                    end
                    else
                    begin
                        // naive restart: only the first character is rechecked
                        lane_pos[i] = (b == key_reg[i][7:0]) ? 4'd1 : 4'd0;
                    end
                end
            end
        end
        else if (op == OP_TICK)
        begin
            if (elapsed != 16'hFFFF)
                elapsed = elapsed + 1'b1;
            if (elapsed >= timeout_reg)
            begin
                search_on         = 1'b0;
                verdict.timed_out = 1'b1;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic stim_row_t req_row(input logic [OP_W-1:0] op, input logic [7:0] b);
        stim_row_t row;
        row         = '0;
        row.op      = op;
        row.data    = {56'd0, b};
        return row;
    endfunction

    function automatic stim_row_t end_row(input logic [OP_W-1:0] op,
                                          input logic [LANE_ID_W-1:0] lane,
                                          input logic timed_out);
        stim_row_t row;
        row           = '0;
        row.op        = op;
        row.typed     = 1'b1;
        row.lane      = lane;
        row.timed_out = timed_out;
        return row;
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [KEY_W-1:0] data);
        stim_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = data;
        return row;
    endfunction

    function automatic logic [KEY_W-1:0] random_reg_value(input logic [CFG_IDX_W-1:0] idx);
        logic [KEY_W-1:0] v;
        int               j;
        v = '0;
        case (idx)
            REG_KEY_LENGTHS:
            begin
                if ($urandom_range(0, 3) == 0)
                    v[15:0] = 16'($urandom_range(0, 16'hFFFF));
                else
                    for (j = 0; j < 4; j++)
                        v[4*j +: 4] = 4'($urandom_range(1, 4));
            end
            REG_KEY_COUNT:
                v[2:0] = ($urandom_range(0, 2) == 0) ? 3'($urandom_range(0, 7)) : 3'(LANES);
            REG_TIMEOUT:
            begin
                case ($urandom_range(0, 9))
                    0:       v[15:0] = 16'd0;
                    1:       v[15:0] = 16'hFFFF;
                    2:       v[15:0] = 16'($urandom_range(0, 16'hFFFF));
                    default: v[15:0] = 16'($urandom_range(1, 40));
                endcase
            end
            default:
            begin
                // keywords: mostly a three-letter alphabet so matches come often
                if ($urandom_range(0, 4) == 0)
                    v = {$urandom, $urandom};
                else
                    for (j = 0; j < 8; j++)
                        v[8*j +: 8] = 8'h41 + 8'($urandom_range(0, 2));
            end
        endcase
        return v;
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_KEYWORD_A, REG_KEYWORD_B, REG_KEYWORD_C, REG_KEYWORD_D:
                key_reg[idx[1:0]] = val;
            REG_KEY_LENGTHS: key_lens    = val[15:0];
            REG_KEY_COUNT:   key_count   = val[CNT_W-1:0];
            REG_TIMEOUT:     timeout_reg = val[TICK_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Drop the request stream and wait until the block has nothing in flight.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_ends.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic send_request(input logic [OP_W-1:0] op, input logic [7:0] b,
                                input logic typed, input search_end_t given);
        int          gap;
        search_end_t verdict;
        logic        ended;
        gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        if (op == OP_START || (search_on && (op == OP_BYTE || op == OP_TICK)))
            live_items++;
        ended = matcher_step(op, b, verdict);
        if (typed)
            verdict = given;
        if (typed || ended)
        begin
            pending_ends.push_back(verdict);
            if (verdict.timed_out)
                n_timeouts++;
            else
                n_matches++;
        end
    endtask

    // result side: random back-pressure, compare against the oldest pending end
    initial
    begin
        int          stall;
        search_end_t want;
        @(posedge rst_n);
        forever
        begin
            stall = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            if (pending_ends.size() == 0)
                flag_mismatch($sformatf("result lane=%0d timeout=%0b with no search pending",
                                        m_tdata, m_tuser));
            else
            begin
                want = pending_ends.pop_front();
                if (m_tdata !== {5'b0, want.lane})
                    flag_mismatch($sformatf("match lane %0d, expected %0d", m_tdata, want.lane));
                if (m_tuser !== want.timed_out)
                    flag_mismatch($sformatf("timeout flag %0b, expected %0b",
                                            m_tuser, want.timed_out));
            end
        end
    end

    initial
    begin
        int          i;
        int          r;
        int          k;
        int          lane;
        int          n;
        int          phase_start;
        int          wait_cyc;
        logic [OP_W-1:0] op;
        logic [7:0]  b;
        stim_row_t   row;

        for (i = 0; i < KEY_REGS; i++)
            key_reg[i] = '0;
        for (i = 0; i < LANES; i++)
            lane_pos[i] = '0;
        key_lens    = '0;
        key_count   = '0;
        timeout_reg = '0;
        elapsed     = '0;
        search_on   = 1'b0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;

        // reset registers give a zero timeout, so the first start ends at once
        directed_rows.push_back(end_row(OP_START, 3'd0, 1'b1));
        directed_rows.push_back(req_row(OP_BYTE, 8'h00));
        directed_rows.push_back(req_row(OP_TICK, 8'h00));
        directed_rows.push_back(req_row(OP_UNUSED, 8'hFF));
        // "AAB", eight 0xFF, eight zeros (length clamped), lane 3 off, count clamped
        directed_rows.push_back(reg_row(REG_KEYWORD_A, 64'h0000_0000_0042_4141));
        directed_rows.push_back(reg_row(REG_KEYWORD_B, 64'hFFFF_FFFF_FFFF_FFFF));
        directed_rows.push_back(reg_row(REG_KEYWORD_C, 64'h0));
        directed_rows.push_back(reg_row(REG_KEYWORD_D, 64'h5A));
        directed_rows.push_back(reg_row(REG_KEY_LENGTHS, 64'h0F83));
        directed_rows.push_back(reg_row(REG_KEY_COUNT, 64'd7));
        directed_rows.push_back(reg_row(REG_TIMEOUT, 64'd3));
        directed_rows.push_back(req_row(OP_START, 8'h00));
        // "AAAB" misses because of the naive restart, then "AAB" hits lane 0
        directed_rows.push_back(req_row(OP_BYTE, 8'h41));
        directed_rows.push_back(req_row(OP_BYTE, 8'h41));
        directed_rows.push_back(req_row(OP_BYTE, 8'h41));
        directed_rows.push_back(req_row(OP_BYTE, 8'h42));
        directed_rows.push_back(req_row(OP_BYTE, 8'h41));
        directed_rows.push_back(req_row(OP_BYTE, 8'h41));
        directed_rows.push_back(req_row(OP_BYTE, 8'h42));
        directed_rows.push_back(req_row(OP_START, 8'h00));
        for (i = 0; i < 8; i++)
            directed_rows.push_back(req_row(OP_BYTE, 8'hFF));
        // a restart in mid-search clears the tick count
        directed_rows.push_back(req_row(OP_START, 8'h00));
        directed_rows.push_back(req_row(OP_TICK, 8'h00));
        directed_rows.push_back(req_row(OP_START, 8'h00));
        directed_rows.push_back(req_row(OP_TICK, 8'h00));
        directed_rows.push_back(req_row(OP_TICK, 8'h00));
        directed_rows.push_back(end_row(OP_TICK, 3'd0, 1'b1));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.is_cfg)
            begin
                settle();
                cfg_write(row.idx, row.data);
            end
            else
                send_request(row.op, row.data[7:0], row.typed, {row.lane, row.timed_out});
        end

        live_items = 0;
        while (live_items < RANDOM_ITEMS)
        begin
            settle();
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            for (r = REG_KEYWORD_A; r <= REG_TIMEOUT; r++)
                if (phases == 0 || $urandom_range(0, 2) != 0)
                    cfg_write(CFG_IDX_W'(r), random_reg_value(CFG_IDX_W'(r)));
            if ($urandom_range(0, 3) == 0)
                cfg_write(REG_UNMAPPED, {$urandom, $urandom});
            burst_q.delete();
            phase_start = live_items;
            while (live_items - phase_start < PHASE_ITEMS)
            begin
                k = $urandom_range(0, 39);
                b = 8'($urandom_range(0, 255));
                if ((!search_on && $urandom_range(0, 1) == 0) || k < 3)
                    op = OP_START;
                else if (k < 8)
                    op = OP_TICK;
                else if (k == 8)
                    op = OP_UNUSED;
                else
                begin
                    op = OP_BYTE;
                    if (burst_q.size() == 0 && $urandom_range(0, 7) == 0)
                    begin
                        // replay a whole keyword so long or random ones complete too
                        lane = $urandom_range(0, LANES - 1);
                        n    = lane_len(lane);
                        if (n == 0)
                            n = $urandom_range(1, MAX_KEY_LEN);
                        for (i = 0; i < n; i++)
                            burst_q.push_back(key_reg[lane][8*i +: 8]);
                    end
                    if (burst_q.size() != 0)
                        b = burst_q.pop_front();
                    else if ($urandom_range(0, 9) < 7)
                        b = 8'h41 + 8'($urandom_range(0, 2));
                end
                send_request(op, b, 1'b0, '0);
            end
            phases++;
        end

        s_tvalid <= 1'b0;
        for (wait_cyc = 0; wait_cyc < 2000 && pending_ends.size() != 0; wait_cyc++)
            @(posedge clk);
        while (pending_ends.size() != 0)
        begin
            flag_mismatch("search end predicted but never delivered");
            void'(pending_ends.pop_front());
        end
        repeat (8) @(posedge clk);

        $display("ran %0d directed rows and %0d random phases (%0d live requests)",
                 directed_rows.size(), phases, live_items);
        $display("searches ended: %0d on a keyword, %0d on timeout; %0d mismatches",
                 n_matches, n_timeouts, errors);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/mksm_pkg.sv
hw/rtl/mksm_lane.sv
hw/rtl/multi_keyword_stream_matcher_unit.sv
sim/testbench.sv
